[rtl/rpc_pkg.sv]
// ----------------------------------------------------------------------------
// rpc_pkg: shared definitions for the rectangular/polar converter
// Angle table, fixed-point formats and the control word that travels
// down the rotator chain.
// ----------------------------------------------------------------------------
package rpc_pkg;

   localparam int DEF_SAMPLE_WIDTH    = 16;
   localparam int DEF_ROTATION_STAGES = 16;

   // Phase fields are binary angles, 2^PHASE_WIDTH is a full turn
   localparam int PHASE_WIDTH = 16;
   // Rotator angle, 2^ANGLE_WIDTH is a full turn
   localparam int ANGLE_WIDTH = 32;
   localparam int GUARD_BITS  = 8;
   // Headroom for CORDIC gain and the sqrt(2) of a diagonal vector
   localparam int HEADROOM    = 3;

   // Inverse CORDIC gain 0.60725... in Q20, held as a signed constant
   localparam int GAIN_FRAC   = 20;
   localparam int GAIN_WIDTH  = GAIN_FRAC + 1;
   localparam logic signed [GAIN_WIDTH-1:0] INV_GAIN = GAIN_WIDTH'(636750);

   // Quarter turn in the phase field format
   localparam logic signed [PHASE_WIDTH-1:0] PHASE_QUARTER = PHASE_WIDTH'(16384);

   localparam int ATAN_ENTRIES = 24;

   // round(atan(2^-i) / (2*pi) * 2^32)
   localparam logic [ANGLE_WIDTH-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic {
      MODE_TO_POLAR = 1'b0,
      MODE_TO_RECT  = 1'b1
   } mode_type;

   // Control word that rides along each stage of the rotator
   typedef struct packed {
      logic     valid;
      mode_type mode;
      logic     zero;    // cartesian request was the zero vector
   } ctl_type;

endpackage

[rtl/rpc_ifs.sv]
// ----------------------------------------------------------------------------
// rpc_ifs: request and response channels of the converter
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface rpc_req_if
   import rpc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) ();
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic signed [SAMPLE_WIDTH-1:0] real_in;
   logic signed [SAMPLE_WIDTH-1:0] imag_in;
   logic        [SAMPLE_WIDTH-1:0] magnitude_in;
   logic signed [PHASE_WIDTH-1:0]  phase_in;

   modport source (output valid, mode, real_in, imag_in, magnitude_in, phase_in,
                   input ready);
   modport sink   (input valid, mode, real_in, imag_in, magnitude_in, phase_in,
                   output ready);
endinterface

interface rpc_rsp_if
   import rpc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) ();
   logic                           valid;
   logic                           ready;
   logic                           mode_out;
   logic        [SAMPLE_WIDTH-1:0] magnitude_out;
   logic signed [PHASE_WIDTH-1:0]  phase_out;
   logic signed [SAMPLE_WIDTH:0]   real_out;
   logic signed [SAMPLE_WIDTH:0]   imag_out;

   modport source (output valid, mode_out, magnitude_out, phase_out, real_out, imag_out,
                   input ready);
   modport sink   (input valid, mode_out, magnitude_out, phase_out, real_out, imag_out,
                   output ready);
endinterface

[rtl/rect_polar_converter.sv]
// ----------------------------------------------------------------------------
// rect_polar_converter: pipelined CORDIC rectangular/polar converter
//
//   channel  | dir | handshake          | contents
//   ---------+-----+--------------------+----------------------------------
//   req_if   | in  | valid/ready        | mode, real/imag or magnitude/phase
//   rsp_if   | out | valid/ready        | mode echo, magnitude/phase or re/im
//
// One request per cycle is taken while the output side keeps up.
// A result passes through the setup stage, one cell per micro-rotation,
// the gain multiply stage and the output register.
// Reset clears the valid bits of every stage and of the output side.
// A stalled response parks the next result in a skid register; the whole
// pipeline holds, and req_if.ready is low, only while that register is full.
// ----------------------------------------------------------------------------
module rect_polar_converter
   import rpc_pkg::*;
#(
   parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH,
   parameter int ROTATION_STAGES = DEF_ROTATION_STAGES
) (
   input  logic      clock,
   input  logic      reset,
   rpc_req_if.sink   req_if,
   rpc_rsp_if.source rsp_if
);

   localparam int XW = SAMPLE_WIDTH + GUARD_BITS + HEADROOM;
   localparam int NS = (ROTATION_STAGES < ATAN_ENTRIES) ? ROTATION_STAGES : ATAN_ENTRIES;

   logic enable;

   ctl_type                       ctl_chain [NS+1];
   logic signed [XW-1:0]          x_chain   [NS+1];
   logic signed [XW-1:0]          y_chain   [NS+1];
   logic        [ANGLE_WIDTH-1:0] z_chain   [NS+1];

   logic                           p_valid;
   logic                           p_mode;
   logic        [SAMPLE_WIDTH-1:0] p_mag;
   logic signed [PHASE_WIDTH-1:0]  p_phase;
   logic signed [SAMPLE_WIDTH:0]   p_real;
   logic signed [SAMPLE_WIDTH:0]   p_imag;

   logic                           out_valid_ff, out_valid_in;
   logic                           out_mode_ff;
   logic        [SAMPLE_WIDTH-1:0] out_mag_ff;
   logic signed [PHASE_WIDTH-1:0]  out_phase_ff;
   logic signed [SAMPLE_WIDTH:0]   out_real_ff;
   logic signed [SAMPLE_WIDTH:0]   out_imag_ff;

   logic                           skid_valid_ff, skid_valid_in;
   logic                           skid_mode_ff;
   logic        [SAMPLE_WIDTH-1:0] skid_mag_ff;
   logic signed [PHASE_WIDTH-1:0]  skid_phase_ff;
   logic signed [SAMPLE_WIDTH:0]   skid_real_ff;
   logic signed [SAMPLE_WIDTH:0]   skid_imag_ff;

   logic out_take;
   logic load_out_pipe;
   logic load_out_skid;
   logic load_skid;

   assign enable       = ~skid_valid_ff;
   assign req_if.ready = enable;

   rpc_prep #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .XW           (XW)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_if.valid),
      .in_mode  (req_if.mode),
      .in_real  (req_if.real_in),
      .in_imag  (req_if.imag_in),
      .in_mag   (req_if.magnitude_in),
      .in_phase (req_if.phase_in),
      .out_ctl  (ctl_chain[0]),
      .out_x    (x_chain[0]),
      .out_y    (y_chain[0]),
      .out_z    (z_chain[0])
   );

   for (genvar i = 0; i < NS; i++) begin : g_cell
      rpc_cell #(
         .XW    (XW),
         .STAGE (i),
         .ANGLE (ATAN_TABLE[i])
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .in_ctl  (ctl_chain[i]),
         .in_x    (x_chain[i]),
         .in_y    (y_chain[i]),
         .in_z    (z_chain[i]),
         .out_ctl (ctl_chain[i+1]),
         .out_x   (x_chain[i+1]),
         .out_y   (y_chain[i+1]),
         .out_z   (z_chain[i+1])
      );
   end

   rpc_gain #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .XW           (XW)
   ) u_gain (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_ctl    (ctl_chain[NS]),
      .in_x      (x_chain[NS]),
      .in_y      (y_chain[NS]),
      .in_z      (z_chain[NS]),
      .out_valid (p_valid),
      .out_mode  (p_mode),
      .out_mag   (p_mag),
      .out_phase (p_phase),
      .out_real  (p_real),
      .out_imag  (p_imag)
   );

   assign out_take = out_valid_ff & rsp_if.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_out_pipe = 1'b0;
      load_out_skid = 1'b0;
      load_skid     = 1'b0;
      if (skid_valid_ff) begin
         // pipeline holds; drain the skid register first
         if (out_take) begin
            load_out_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in  = p_valid;
         load_out_pipe = p_valid;
      end else if (p_valid) begin
         skid_valid_in = 1'b1;
         load_skid     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out_pipe) begin
         out_mode_ff  <= p_mode;
         out_mag_ff   <= p_mag;
         out_phase_ff <= p_phase;
         out_real_ff  <= p_real;
         out_imag_ff  <= p_imag;
      end else if (load_out_skid) begin
         out_mode_ff  <= skid_mode_ff;
         out_mag_ff   <= skid_mag_ff;
         out_phase_ff <= skid_phase_ff;
         out_real_ff  <= skid_real_ff;
         out_imag_ff  <= skid_imag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_skid) begin
         skid_mode_ff  <= p_mode;
         skid_mag_ff   <= p_mag;
         skid_phase_ff <= p_phase;
         skid_real_ff  <= p_real;
         skid_imag_ff  <= p_imag;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.mode_out      = out_mode_ff;
   assign rsp_if.magnitude_out = out_mag_ff;
   assign rsp_if.phase_out     = out_phase_ff;
   assign rsp_if.real_out      = out_real_ff;
   assign rsp_if.imag_out      = out_imag_ff;

endmodule

[rtl/rpc_prep.sv]
// ----------------------------------------------------------------------------
// rpc_prep: operand setup ahead of the rotator chain
// Scales the request into rotator format and folds it into the right half
// plane (to polar) or into +-quarter turn (to rectangular).
// ----------------------------------------------------------------------------
module rpc_prep
   import rpc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int XW           = DEF_SAMPLE_WIDTH + GUARD_BITS + HEADROOM
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           in_valid,
   input  logic                           in_mode,
   input  logic signed [SAMPLE_WIDTH-1:0] in_real,
   input  logic signed [SAMPLE_WIDTH-1:0] in_imag,
   input  logic        [SAMPLE_WIDTH-1:0] in_mag,
   input  logic signed [PHASE_WIDTH-1:0]  in_phase,
   output ctl_type                        out_ctl,
   output logic signed [XW-1:0]           out_x,
   output logic signed [XW-1:0]           out_y,
   output logic        [ANGLE_WIDTH-1:0]  out_z
);

   ctl_type                       ctl_ff, ctl_in;
   logic signed [XW-1:0]          x_ff, x_in;
   logic signed [XW-1:0]          y_ff, y_in;
   logic        [ANGLE_WIDTH-1:0] z_ff, z_in;

   logic signed [XW-1:0]          re_ext;
   logic signed [XW-1:0]          im_ext;
   logic signed [XW-1:0]          mag_ext;
   logic        [ANGLE_WIDTH-1:0] phase_ext;
   logic                          fold;

   assign re_ext    = XW'(in_real) <<< GUARD_BITS;
   assign im_ext    = XW'(in_imag) <<< GUARD_BITS;
   assign mag_ext   = XW'(in_mag) <<< GUARD_BITS;
   assign phase_ext = {in_phase, (ANGLE_WIDTH - PHASE_WIDTH)'(0)};
   assign fold      = (in_phase > PHASE_QUARTER) || (in_phase < -PHASE_QUARTER);

   always_comb begin
      ctl_in.valid = in_valid;
      ctl_in.mode  = mode_type'(in_mode);
      ctl_in.zero  = (in_real == '0) && (in_imag == '0);
      if (in_mode == MODE_TO_RECT) begin
         // take a half turn off the angle and flip the magnitude
         x_in = fold ? -mag_ext : mag_ext;
         y_in = '0;
         z_in = fold ? {~phase_ext[ANGLE_WIDTH-1], phase_ext[ANGLE_WIDTH-2:0]} : phase_ext;
      end else begin
         // left half plane: negate the vector, start at a half turn
         x_in = in_real[SAMPLE_WIDTH-1] ? -re_ext : re_ext;
         y_in = in_real[SAMPLE_WIDTH-1] ? -im_ext : im_ext;
         z_in = {in_real[SAMPLE_WIDTH-1], (ANGLE_WIDTH - 1)'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;

endmodule

[rtl/rpc_cell.sv]
// ----------------------------------------------------------------------------
// rpc_cell: one micro-rotation of the CORDIC chain
// Rotates (x, y) by +-atan(2^-STAGE) and tracks the angle in z.
// ----------------------------------------------------------------------------
module rpc_cell
   import rpc_pkg::*;
#(
   parameter int                     XW    = DEF_SAMPLE_WIDTH + GUARD_BITS + HEADROOM,
   parameter int                     STAGE = 0,
   parameter logic [ANGLE_WIDTH-1:0] ANGLE = ATAN_TABLE[0]
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  ctl_type                       in_ctl,
   input  logic signed [XW-1:0]          in_x,
   input  logic signed [XW-1:0]          in_y,
   input  logic        [ANGLE_WIDTH-1:0] in_z,
   output ctl_type                       out_ctl,
   output logic signed [XW-1:0]          out_x,
   output logic signed [XW-1:0]          out_y,
   output logic        [ANGLE_WIDTH-1:0] out_z
);

   ctl_type                       ctl_ff;
   logic signed [XW-1:0]          x_ff, x_in;
   logic signed [XW-1:0]          y_ff, y_in;
   logic        [ANGLE_WIDTH-1:0] z_ff, z_in;

   logic signed [XW-1:0] x_shr;
   logic signed [XW-1:0] y_shr;
   logic                 turn_back;

   assign x_shr = in_x >>> STAGE;
   assign y_shr = in_y >>> STAGE;

   // vectoring drives y to zero, rotation drives z to zero
   assign turn_back = (in_ctl.mode == MODE_TO_RECT) ? ~in_z[ANGLE_WIDTH-1] : in_y[XW-1];

   always_comb begin
      if (turn_back) begin
         x_in = in_x - y_shr;
         y_in = in_y + x_shr;
         z_in = in_z - ANGLE;
      end else begin
         x_in = in_x + y_shr;
         y_in = in_y - x_shr;
         z_in = in_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;

endmodule

[rtl/rpc_gain.sv]
// ----------------------------------------------------------------------------
// rpc_gain: gain compensation and result formatting
// Registers x and y times the inverse CORDIC gain, then rounds, saturates
// and zeroes the fields the conversion direction does not use.
// ----------------------------------------------------------------------------
module rpc_gain
   import rpc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int XW           = DEF_SAMPLE_WIDTH + GUARD_BITS + HEADROOM
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  ctl_type                        in_ctl,
   input  logic signed [XW-1:0]           in_x,
   input  logic signed [XW-1:0]           in_y,
   input  logic        [ANGLE_WIDTH-1:0]  in_z,
   output logic                           out_valid,
   output logic                           out_mode,
   output logic        [SAMPLE_WIDTH-1:0] out_mag,
   output logic signed [PHASE_WIDTH-1:0]  out_phase,
   output logic signed [SAMPLE_WIDTH:0]   out_real,
   output logic signed [SAMPLE_WIDTH:0]   out_imag
);

   localparam int PW    = XW + GAIN_WIDTH;
   localparam int SHIFT = GAIN_FRAC + GUARD_BITS;
   localparam logic signed [PW-1:0] ROUND_BIAS = PW'(64'd1 << (SHIFT - 1));

   ctl_type                       ctl_ff;
   logic signed [PW-1:0]          prod_x_ff, prod_x_in;
   logic signed [PW-1:0]          prod_y_ff, prod_y_in;
   logic signed [PHASE_WIDTH-1:0] phase_ff, phase_in;

   logic        [ANGLE_WIDTH-1:0] z_round;
   logic signed [PW-1:0]          sx;
   logic signed [PW-1:0]          sy;
   logic        [SAMPLE_WIDTH-1:0] mag_sat;
   logic signed [SAMPLE_WIDTH:0]   re_sat;
   logic signed [SAMPLE_WIDTH:0]   im_sat;

   assign prod_x_in = PW'(in_x) * PW'(INV_GAIN);
   assign prod_y_in = PW'(in_y) * PW'(INV_GAIN);
   assign z_round   = in_z + ANGLE_WIDTH'(32'h0000_8000);
   assign phase_in  = in_ctl.zero ? '0 : z_round[ANGLE_WIDTH-1 -: PHASE_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         phase_ff  <= phase_in;
      end
   end

   // round half up, then drop guard and gain fraction bits
   assign sx = (prod_x_ff + ROUND_BIAS) >>> SHIFT;
   assign sy = (prod_y_ff + ROUND_BIAS) >>> SHIFT;

   always_comb begin
      if (sx[PW-1]) begin
         mag_sat = '0;
      end else if (sx[PW-1:SAMPLE_WIDTH] != '0) begin
         mag_sat = '1;
      end else begin
         mag_sat = sx[SAMPLE_WIDTH-1:0];
      end

      // in range when the top bits are a sign extension of bit SAMPLE_WIDTH
      if ((sx[PW-1:SAMPLE_WIDTH] == '0) || (sx[PW-1:SAMPLE_WIDTH] == '1)) begin
         re_sat = sx[SAMPLE_WIDTH:0];
      end else begin
         re_sat = {sx[PW-1], {SAMPLE_WIDTH{~sx[PW-1]}}};
      end

      if ((sy[PW-1:SAMPLE_WIDTH] == '0) || (sy[PW-1:SAMPLE_WIDTH] == '1)) begin
         im_sat = sy[SAMPLE_WIDTH:0];
      end else begin
         im_sat = {sy[PW-1], {SAMPLE_WIDTH{~sy[PW-1]}}};
      end
   end

   always_comb begin
      out_valid = ctl_ff.valid;
      out_mode  = ctl_ff.mode;
      if (ctl_ff.mode == MODE_TO_RECT) begin
         out_mag   = '0;
         out_phase = '0;
         out_real  = re_sat;
         out_imag  = im_sat;
      end else begin
         out_mag   = mag_sat;
         out_phase = phase_ff;
         out_real  = '0;
         out_imag  = '0;
      end
   end

endmodule
